@@ rtl/lsamu_pkg.sv @@
// ----------------------------------------------------------------------------
// lsamu_pkg
// Shared types and codes for the load/store/atomic memory unit.
// ----------------------------------------------------------------------------
package lsamu_pkg;

  // Field widths fixed by the transaction format
  localparam int KIND_W      = 3;
  localparam int OP_W        = 4;
  localparam int SIZE_W      = 2;
  localparam int ADDR_W      = 15;
  localparam int WORD_ADDR_W = ADDR_W - 3;
  localparam int DATA_W      = 64;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LR    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SC    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_AMO   = 3'd4;

  // Atomic operations
  localparam logic [OP_W-1:0] AMO_SWAP = 4'd0;
  localparam logic [OP_W-1:0] AMO_ADD  = 4'd1;
  localparam logic [OP_W-1:0] AMO_XOR  = 4'd2;
  localparam logic [OP_W-1:0] AMO_AND  = 4'd3;
  localparam logic [OP_W-1:0] AMO_OR   = 4'd4;
  localparam logic [OP_W-1:0] AMO_MIN  = 4'd5;
  localparam logic [OP_W-1:0] AMO_MAX  = 4'd6;
  localparam logic [OP_W-1:0] AMO_MINU = 4'd7;
  localparam logic [OP_W-1:0] AMO_MAXU = 4'd8;

  // Access sizes
  localparam logic [SIZE_W-1:0] SIZE_B = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_H = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_W32 = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_D = 2'd3;

  // Request payload
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OP_W-1:0]   amo_op;
    logic [SIZE_W-1:0] size_log2;
    logic              zero_ext;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] store_data;
  } req_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;      // capture request
    logic calc_quot;  // register word index quotient
    logic calc_idx;   // register word index
    logic mem_read;   // registered memory read
    logic exec;       // compute, write back, load result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip;       // faulting or ignored request, no memory access
  } status_t;

endpackage

@@ rtl/lsamu_ifs.sv @@
// ----------------------------------------------------------------------------
// lsamu request / response interfaces
// Valid/ready channels carrying the request and response transactions.
// ----------------------------------------------------------------------------
interface lsamu_req_if;
  import lsamu_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [OP_W-1:0]     amo_op;
  logic [SIZE_W-1:0]   size_log2;
  logic                zero_ext;
  logic [ADDR_W-1:0]   address;
  logic [DATA_W-1:0]   store_data;

  modport source (output valid, kind, amo_op, size_log2, zero_ext, address,
                  store_data, input ready);
  modport sink (input valid, kind, amo_op, size_log2, zero_ext, address,
                store_data, output ready);
endinterface

interface lsamu_rsp_if;
  import lsamu_pkg::*;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_value;
  logic                fault;

  modport source (output valid, read_value, fault, input ready);
  modport sink (input valid, read_value, fault, output ready);
endinterface

@@ rtl/lsamu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsamu_ctrl
// Sequencer: steps one request through index, read and execute.
// ----------------------------------------------------------------------------
module lsamu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lsamu_pkg::status_t status,
  output lsamu_pkg::cmd_t    cmd
);
  import lsamu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_QUOT = 3'd1;
  localparam logic [2:0] S_IDX  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       fire;

  // result register free or being emptied this cycle
  assign fire     = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // commands
  always_comb begin
    cmd.latch     = in_valid && in_ready;
    cmd.calc_quot = (state == S_QUOT);
    cmd.calc_idx  = (state == S_IDX);
    cmd.mem_read  = (state == S_READ);
    cmd.exec      = (state == S_EXEC) && fire;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_QUOT;
      S_QUOT: state_next = S_IDX;
      S_IDX:  state_next = status.skip ? S_EXEC : S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is in flight");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("execute did not present a result");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch, cmd.calc_quot, cmd.calc_idx, cmd.mem_read, cmd.exec}))
    else $error("overlapping datapath commands");
`endif

endmodule

@@ rtl/lsamu_dpath.sv @@
// ----------------------------------------------------------------------------
// lsamu_dpath
// Request registers, word index reduction, data memory, reservation and
// the load/store/AMO execute logic with the result register.
// ----------------------------------------------------------------------------
module lsamu_dpath #(
  parameter int MEM_WORDS = 4096,
  parameter int XLEN      = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lsamu_pkg::cmd_t                cmd,
  input  lsamu_pkg::req_t                req_in,
  output lsamu_pkg::status_t             status,
  output logic [lsamu_pkg::DATA_W-1:0]   read_value,
  output logic                           fault
);
  import lsamu_pkg::*;

  localparam int IW = $clog2(MEM_WORDS);
  localparam logic [DATA_W-1:0] XMASK = {DATA_W{1'b1}} >> (DATA_W - XLEN);

  req_t                   req;
  logic [WORD_ADDR_W-1:0] word_addr;
  logic [IW-1:0]          idx_comb;
  logic [IW-1:0]          idx;
  logic [DATA_W-1:0]      rdata;
  logic [DATA_W-1:0]      mem [MEM_WORDS];

  logic                   nop;
  logic                   misaligned;
  logic [5:0]             shamt;
  logic [DATA_W-1:0]      lane;
  logic [DATA_W-1:0]      old;
  logic [DATA_W-1:0]      sold;
  logic [DATA_W-1:0]      sop;
  logic [DATA_W-1:0]      amo_res;
  logic [DATA_W-1:0]      wr_data;
  logic [DATA_W-1:0]      new_word;
  logic [DATA_W-1:0]      val;
  logic                   sc_ok;
  logic                   wr_en;

  logic [ADDR_W-1:0]      resv_addr;
  logic                   resv_valid;

  function automatic logic [DATA_W-1:0] sext(input logic [DATA_W-1:0] v,
                                             input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] r;
    case (sz)
      SIZE_B:   r = {{56{v[7]}}, v[7:0]};
      SIZE_H:   r = {{48{v[15]}}, v[15:0]};
      SIZE_W32: r = {{32{v[31]}}, v[31:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) req <= req_in;
  end

  assign word_addr = req.address[ADDR_W-1:3];

  // word index = word address modulo memory depth
  if (MEM_WORDS >= (1 << WORD_ADDR_W)) begin : g_idx_wide
    assign idx_comb = IW'(word_addr);
  end else if ((MEM_WORDS & (MEM_WORDS - 1)) == 0) begin : g_idx_pow2
    assign idx_comb = word_addr[IW-1:0];
  end else begin : g_idx_recip
    // quotient by reciprocal, exact for all 12-bit word addresses
    localparam int SH    = 2 * WORD_ADDR_W;
    localparam int RECIP = (1 << SH) / MEM_WORDS + 1;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = WORD_ADDR_W + RW;
    logic [PW-1:0]          prod;
    logic [PW-SH-1:0]       quot;
    logic [WORD_ADDR_W-1:0] qm;
    logic [WORD_ADDR_W-1:0] rem;
    assign prod = PW'(word_addr) * PW'(RECIP);
    always_ff @(posedge clk) begin
      if (cmd.calc_quot) quot <= prod[PW-1:SH];
    end
    assign qm       = WORD_ADDR_W'(quot) * WORD_ADDR_W'(MEM_WORDS);
    assign rem      = word_addr - qm;
    assign idx_comb = rem[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_idx) idx <= idx_comb;
  end

  // request decode
  always_comb begin
    nop = (req.kind > KIND_AMO) ||
          ((req.kind >= KIND_LR) && (req.size_log2 < SIZE_W32)) ||
          ((req.kind == KIND_AMO) && (req.amo_op > AMO_MAXU)) ||
          ((req.size_log2 == SIZE_D) && (XLEN < 64));
    case (req.size_log2)
      SIZE_B:   misaligned = 1'b0;
      SIZE_H:   misaligned = req.address[0];
      SIZE_W32: misaligned = |req.address[1:0];
      default:  misaligned = |req.address[2:0];
    endcase
  end

  assign status.skip = nop || misaligned;

  // lane extraction
  always_comb begin
    case (req.size_log2)
      SIZE_B:   lane = 64'h0000_0000_0000_00ff;
      SIZE_H:   lane = 64'h0000_0000_0000_ffff;
      SIZE_W32: lane = 64'h0000_0000_ffff_ffff;
      default:  lane = {DATA_W{1'b1}};
    endcase
    shamt = {req.address[2:0], 3'b000};
    old   = (rdata >> shamt) & lane;
    sold  = sext(old, req.size_log2);
    sop   = sext(req.store_data, req.size_log2);
  end

  // atomic ALU
  always_comb begin
    case (req.amo_op)
      AMO_SWAP: amo_res = req.store_data;
      AMO_ADD:  amo_res = old + req.store_data;
      AMO_XOR:  amo_res = old ^ req.store_data;
      AMO_AND:  amo_res = old & req.store_data;
      AMO_OR:   amo_res = old | req.store_data;
      AMO_MIN:  amo_res = ($signed(sold) < $signed(sop)) ? old : req.store_data;
      AMO_MAX:  amo_res = ($signed(sop) < $signed(sold)) ? old : req.store_data;
      AMO_MINU: amo_res = (old < (req.store_data & lane)) ? old : req.store_data;
      default:  amo_res = (old > (req.store_data & lane)) ? old : req.store_data;
    endcase
  end

  // per-kind result and write enable
  always_comb begin
    sc_ok   = resv_valid && (resv_addr == req.address);
    wr_en   = 1'b0;
    wr_data = req.store_data;
    val     = '0;
    case (req.kind)
      KIND_LOAD:  val = req.zero_ext ? old : sold;
      KIND_STORE: wr_en = 1'b1;
      KIND_LR:    val = sold;
      KIND_SC: begin
        wr_en = sc_ok;
        val   = sc_ok ? '0 : DATA_W'(1);
      end
      KIND_AMO: begin
        wr_en   = 1'b1;
        wr_data = amo_res;
        val     = sold;
      end
      default: val = '0;
    endcase
    if (status.skip || !cmd.exec) begin
      wr_en = 1'b0;
    end
    if (status.skip) begin
      val = '0;
    end
    new_word = (rdata & ~(lane << shamt)) | ((wr_data & lane) << shamt);
  end

  // data memory
  always_ff @(posedge clk) begin
    if (cmd.mem_read) rdata <= mem[idx];
    if (wr_en) mem[idx] <= new_word;
  end

  // reservation
  always_ff @(posedge clk) begin
    if (rst) begin
      resv_addr  <= '0;
      resv_valid <= 1'b0;
    end else if (cmd.exec && !status.skip) begin
      if (req.kind == KIND_LR) begin
        resv_addr  <= req.address;
        resv_valid <= 1'b1;
      end else if (req.kind == KIND_SC) begin
        resv_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_value <= val & XMASK;
      fault      <= misaligned && !nop;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_at_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> cmd.exec && !status.skip)
    else $error("memory write outside execute");
  a_sc_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !status.skip && (req.kind == KIND_SC) |=> !resv_valid)
    else $error("store-conditional left reservation set");
  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && misaligned |=> $stable(resv_valid) && $stable(resv_addr))
    else $error("misaligned access changed the reservation");
`endif

endmodule

@@ rtl/load_store_atomic_memory_unit_top.sv @@
// ----------------------------------------------------------------------------
// load_store_atomic_memory_unit_top
// RV64A-style load/store/LR/SC/AMO unit over a local 64-bit word memory.
//
//   channel | direction | payload
//   req     | in        | kind, amo_op, size_log2, zero_ext, address,
//           |           | store_data
//   rsp     | out       | read_value, fault
//
// One transaction at a time. Each access steps through capture, index quotient,
// index remainder, registered memory read and execute; a faulting or
// ignored request skips the memory read. The result is registered when
// execute completes.
// The next request is accepted in the cycle after the result is registered,
// even while that result still waits on rsp.
// A stalled rsp holds the unit in execute until the result register frees.
// Synchronous reset clears the sequencer and the reservation; memory words
// are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module load_store_atomic_memory_unit_top #(
  parameter int MEM_WORDS = 4096,
  parameter int XLEN      = 64
) (
  input logic         clk,
  input logic         rst,
  lsamu_req_if.sink   req,
  lsamu_rsp_if.source rsp
);
  import lsamu_pkg::*;

  cmd_t    cmd;
  status_t status;
  req_t    req_in;

  assign req_in.kind        = req.kind;
  assign req_in.amo_op      = req.amo_op;
  assign req_in.size_log2   = req.size_log2;
  assign req_in.zero_ext    = req.zero_ext;
  assign req_in.address     = req.address;
  assign req_in.store_data  = req.store_data;

  lsamu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lsamu_dpath #(
    .MEM_WORDS (MEM_WORDS),
    .XLEN      (XLEN)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_in     (req_in),
    .status     (status),
    .read_value (rsp.read_value),
    .fault      (rsp.fault)
  );

endmodule
